### hdl/assert_macros.svh
// assertion macros shared by the timer rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle, sampled on clk, off in reset
`define ASSERT_IMPLIES(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("timer assertion failed");

// antecedent implies consequent in the next cycle, sampled on clk, off in reset
`define ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("timer assertion failed");

`endif

### hdl/upt_pkg.sv
// types and register constants of the timer
`default_nettype none

package upt_pkg;

    // request op codes
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;

    // register map
    localparam logic [2:0] REG_CTRL     = 3'd0;
    localparam logic [2:0] REG_IRQ_EN   = 3'd1;
    localparam logic [2:0] REG_STATUS   = 3'd2;
    localparam logic [2:0] REG_EVENT    = 3'd3;
    localparam logic [2:0] REG_COUNT    = 3'd4;
    localparam logic [2:0] REG_PRESCALE = 3'd5;
    localparam logic [2:0] REG_RELOAD   = 3'd6;

    // register bit positions
    localparam int CTRL_EN_BIT      = 0;
    localparam int CTRL_URS_BIT     = 2;
    localparam int CTRL_OPM_BIT     = 3;
    localparam int EVENT_UPDATE_BIT = 0;
    localparam int STATUS_FLAG_BIT  = 0;
    localparam int IRQEN_UPDATE_BIT = 0;

    localparam int DATA_WIDTH = 16;

    typedef struct packed {
        logic [1:0]            op;
        logic [2:0]            reg_sel;
        logic [DATA_WIDTH-1:0] write_data;
    } step_t;

    typedef struct packed {
        logic [DATA_WIDTH-1:0] read_data;
        logic                  irq;
    } result_t;

    typedef struct packed {
        logic update_flag;
        logic update_irq_enable;
    } status_t;

endpackage

`default_nettype wire

### hdl/upt_req_if.sv
// request channel of the timer
`default_nettype none

interface upt_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  op;
    logic [2:0]  reg_sel;
    logic [15:0] write_data;

    modport source (output valid, output op, output reg_sel, output write_data, input ready);
    modport sink (input valid, input op, input reg_sel, input write_data, output ready);
endinterface

`default_nettype wire

### hdl/upt_rsp_if.sv
// response channel of the timer
`default_nettype none

interface upt_rsp_if;
    logic        valid;
    logic        ready;
    logic [15:0] read_data;
    logic        irq;

    modport source (output valid, output read_data, output irq, input ready);
    modport sink (input valid, input read_data, input irq, output ready);
endinterface

`default_nettype wire

### hdl/upt_core.sv
// timer register file, prescaler and counter with one-request update logic
`default_nettype none

module upt_core #(
    parameter int COUNT_WIDTH = 16
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            step_en,
    input  wire upt_pkg::step_t  step,
    output upt_pkg::result_t     result,
    output upt_pkg::status_t     status
);

    logic                   enable_reg, enable_next;
    logic                   one_pulse_reg, one_pulse_next;
    logic                   urs_reg, urs_next;
    logic                   uie_reg, uie_next;
    logic                   flag_reg, flag_next;
    logic [COUNT_WIDTH-1:0] count_reg, count_next;
    logic [COUNT_WIDTH-1:0] psc_cnt_reg, psc_cnt_next;
    logic [COUNT_WIDTH-1:0] psc_wr_reg, psc_wr_next;
    logic [COUNT_WIDTH-1:0] psc_act_reg, psc_act_next;
    logic [COUNT_WIDTH-1:0] reload_reg, reload_next;
    logic [COUNT_WIDTH-1:0] wdata;
    logic [upt_pkg::DATA_WIDTH-1:0] rdata;

    assign wdata = COUNT_WIDTH'(step.write_data);

    always_comb
    begin
        enable_next    = enable_reg;
        one_pulse_next = one_pulse_reg;
        urs_next       = urs_reg;
        uie_next       = uie_reg;
        flag_next      = flag_reg;
        count_next     = count_reg;
        psc_cnt_next   = psc_cnt_reg;
        psc_wr_next    = psc_wr_reg;
        psc_act_next   = psc_act_reg;
        reload_next    = reload_reg;
        rdata          = '0;

        case (step.op)
            upt_pkg::OP_TICK:
            begin
                if (enable_reg)
                begin
                    if (psc_cnt_reg < psc_act_reg)
                    begin
                        psc_cnt_next = psc_cnt_reg + COUNT_WIDTH'(1);
                    end
                    else
                    begin
                        psc_cnt_next = '0;
                        if (count_reg == reload_reg)
                        begin
                            // update event
                            count_next   = '0;
                            psc_act_next = psc_wr_reg;
                            flag_next    = 1'b1;
                            if (one_pulse_reg)
                            begin
                                enable_next = 1'b0;
                            end
                        end
                        else
                        begin
                            count_next = count_reg + COUNT_WIDTH'(1);
                        end
                    end
                end
            end
            upt_pkg::OP_READ:
            begin
                case (step.reg_sel)
                    upt_pkg::REG_CTRL:
                    begin
                        rdata[upt_pkg::CTRL_EN_BIT]  = enable_reg;
                        rdata[upt_pkg::CTRL_URS_BIT] = urs_reg;
                        rdata[upt_pkg::CTRL_OPM_BIT] = one_pulse_reg;
                    end
                    upt_pkg::REG_IRQ_EN:   rdata[upt_pkg::IRQEN_UPDATE_BIT] = uie_reg;
                    upt_pkg::REG_STATUS:   rdata[upt_pkg::STATUS_FLAG_BIT] = flag_reg;
                    upt_pkg::REG_COUNT:    rdata = upt_pkg::DATA_WIDTH'(count_reg);
                    upt_pkg::REG_PRESCALE: rdata = upt_pkg::DATA_WIDTH'(psc_wr_reg);
                    upt_pkg::REG_RELOAD:   rdata = upt_pkg::DATA_WIDTH'(reload_reg);
                    default:               rdata = '0;
                endcase
            end
            upt_pkg::OP_WRITE:
            begin
                case (step.reg_sel)
                    upt_pkg::REG_CTRL:
                    begin
                        enable_next    = step.write_data[upt_pkg::CTRL_EN_BIT];
                        urs_next       = step.write_data[upt_pkg::CTRL_URS_BIT];
                        one_pulse_next = step.write_data[upt_pkg::CTRL_OPM_BIT];
                    end
                    upt_pkg::REG_IRQ_EN:
                    begin
                        uie_next = step.write_data[upt_pkg::IRQEN_UPDATE_BIT];
                    end
                    upt_pkg::REG_STATUS:
                    begin
                        // write zero to clear, one leaves the flag alone
                        flag_next = flag_reg & step.write_data[upt_pkg::STATUS_FLAG_BIT];
                    end
                    upt_pkg::REG_EVENT:
                    begin
                        if (step.write_data[upt_pkg::EVENT_UPDATE_BIT])
                        begin
                            count_next   = '0;
                            psc_cnt_next = '0;
                            psc_act_next = psc_wr_reg;
                            if (!urs_reg)
                            begin
                                flag_next = 1'b1;
                            end
                        end
                    end
                    upt_pkg::REG_COUNT:    count_next  = wdata;
                    upt_pkg::REG_PRESCALE: psc_wr_next = wdata;
                    upt_pkg::REG_RELOAD:   reload_next = wdata;
                    default:               reload_next = reload_reg;
                endcase
            end
            default:
            begin
                rdata = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg    <= 1'b0;
            one_pulse_reg <= 1'b0;
            urs_reg       <= 1'b0;
            uie_reg       <= 1'b0;
            flag_reg      <= 1'b0;
            count_reg     <= '0;
            psc_cnt_reg   <= '0;
            psc_wr_reg    <= '0;
            psc_act_reg   <= '0;
            reload_reg    <= '1;
        end
        else if (step_en)
        begin
            enable_reg    <= enable_next;
            one_pulse_reg <= one_pulse_next;
            urs_reg       <= urs_next;
            uie_reg       <= uie_next;
            flag_reg      <= flag_next;
            count_reg     <= count_next;
            psc_cnt_reg   <= psc_cnt_next;
            psc_wr_reg    <= psc_wr_next;
            psc_act_reg   <= psc_act_next;
            reload_reg    <= reload_next;
        end
    end

    assign result.read_data = rdata;
    assign result.irq       = flag_next & uie_next;

    assign status.update_flag       = flag_reg;
    assign status.update_irq_enable = uie_reg;

endmodule

`default_nettype wire

### hdl/update_timer_with_one_pulse.sv
// top level of the prescaled auto-reload timer with one-pulse mode
//
//   channel | dir | payload                       | handshake
//   --------+-----+-------------------------------+-------------
//   req     | in  | op, reg_sel, write_data       | valid/ready
//   rsp     | out | read_data, irq                | valid/ready
//
// one request per clock sustained while rsp.ready stays high; a response follows its request
// through the input register, then the update logic writes state and the result register
// rst_n is asynchronous and clears the control state, reload resets to all ones
// a stalled response holds in the result register while the input register keeps
// one more request; req.ready drops only when both are full
`default_nettype none

`include "assert_macros.svh"

module update_timer_with_one_pulse #(
    parameter int COUNT_WIDTH = 16
) (
    input  wire logic clk,
    input  wire logic rst_n,
    upt_req_if.sink   req,
    upt_rsp_if.source rsp
);

    // input register
    logic             s1_valid_reg;
    upt_pkg::step_t   s1_req_reg;
    logic             s1_advance;

    // result register
    logic             out_valid_reg;
    upt_pkg::result_t out_rsp_reg;

    upt_pkg::result_t core_result;
    upt_pkg::status_t core_status;

    // the held request moves on when the result register is free or being drained
    assign s1_advance = s1_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready  = !s1_valid_reg || s1_advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (req.ready)
        begin
            s1_valid_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            s1_req_reg.op         <= req.op;
            s1_req_reg.reg_sel    <= req.reg_sel;
            s1_req_reg.write_data <= req.write_data;
        end
    end

    // state update and response for the held request
    upt_core #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (s1_advance),
        .step    (s1_req_reg),
        .result  (core_result),
        .status  (core_status)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance)
        begin
            out_rsp_reg <= core_result;
        end
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.read_data = out_rsp_reg.read_data;
    assign rsp.irq       = out_rsp_reg.irq;

    // a request leaving the input register always lands in the result register
    `ASSERT_NEXT(a_advance_fills_out, s1_advance, out_valid_reg)

    // a held request that cannot move stays put
    `ASSERT_NEXT(a_s1_holds, s1_valid_reg && !s1_advance, s1_valid_reg && $stable(s1_req_reg))

    // irq in a fresh response matches the flag and enable just written
    `ASSERT_NEXT(a_irq_matches_state, s1_advance,
        out_rsp_reg.irq == (core_status.update_flag && core_status.update_irq_enable))

endmodule

`default_nettype wire
